// ===== rtl/dmc_pkg.sv =====
// shared types, constants and mask tables for the dual mask 3x3 filter
// no dependencies; used by every module under rtl

package dmc_pkg;

	// fixed field widths
	localparam int PIX_W      = 8;
	localparam int VAL_W      = 13;   // signed working width of a filter sum
	localparam int OUT_A_W    = 12;   // value_a field
	localparam int OUT_B_W    = 13;   // value_b field
	localparam int POS_OUT_W  = 6;    // row and column fields
	localparam int PEAK_A_W   = 10;   // largest mask A peak is 1020 (border pixel times four)
	localparam int PEAK_B_W   = 12;   // largest positive mask B result is 3825
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;

	// size registers after reset
	localparam int RST_SIZE   = 8;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		KIND_BORDER   = 2'd0,
		KIND_INTERIOR = 2'd1,
		KIND_SUMMARY  = 2'd2
	} kind_t;

	// masks in quarters, [row][column], row 0 is two rows up
	typedef int mask_t [3][3];
	localparam mask_t MASK_A = '{'{0, -2, 0}, '{-2, 0, 2}, '{0, -2, 0}};
	localparam mask_t MASK_B = '{'{2, 1, 2}, '{1, 4, 1}, '{2, -2, 2}};

	// one window column, index 0 is the top pixel
	typedef logic [2:0][PIX_W-1:0] col_t;

	// which results an item produces
	typedef struct packed {
		logic summary;
		logic border;
		logic interior;
	} item_flags_t;

	// peak tracker controls
	typedef struct packed {
		logic upd;
		logic int_en;
		logic bord_en;
		logic frame_end;
	} peak_ctl_t;

endpackage

// ===== rtl/dmc_cell.sv =====
// one window column cell: holds three pixels, shifts them to its left neighbor
// and forms this column's share of both mask sums; uses dmc_pkg

module dmc_cell #(
	parameter int COL = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               shift,
	input  dmc_pkg::col_t                      col_in,
	output dmc_pkg::col_t                      col_out,
	output logic signed [dmc_pkg::VAL_W-1:0]   part_a,
	output logic signed [dmc_pkg::VAL_W-1:0]   part_b
);

	dmc_pkg::col_t pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift) begin
			pix_q <= col_in;
		end
	end

	assign col_out = pix_q;

	// constant weights, so each product is a shift or nothing
	always_comb begin
		int sa;
		int sb;
		sa = 0;
		sb = 0;
		for (int i = 0; i < 3; i++) begin
			sa = sa + dmc_pkg::MASK_A[i][COL] * int'(pix_q[i]);
			sb = sb + dmc_pkg::MASK_B[i][COL] * int'(pix_q[i]);
		end
		part_a = sa[dmc_pkg::VAL_W-1:0];
		part_b = sb[dmc_pkg::VAL_W-1:0];
	end

endmodule

// ===== rtl/dmc_peak.sv =====
// peak tracker for one mask: interior candidate first, then border candidate
// strict greater wins, ties go to the earlier raster position; uses dmc_pkg

module dmc_peak #(
	parameter int ROW_W  = 6,
	parameter int COL_W  = 6,
	parameter int PEAK_W = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dmc_pkg::peak_ctl_t               ctl,
	input  logic signed [dmc_pkg::VAL_W-1:0] int_val,
	input  logic [ROW_W-1:0]                 int_row,
	input  logic [COL_W-1:0]                 int_col,
	input  logic signed [dmc_pkg::VAL_W-1:0] bord_val,
	input  logic [ROW_W-1:0]                 bord_row,
	input  logic [COL_W-1:0]                 bord_col,
	output logic [PEAK_W-1:0]                peak_val,
	output logic [ROW_W-1:0]                 peak_row,
	output logic [COL_W-1:0]                 peak_col
);

	localparam int VW = dmc_pkg::VAL_W;

	logic [PEAK_W-1:0] val_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [PEAK_W-1:0] mid_val;
	logic [ROW_W-1:0]  mid_row;
	logic [COL_W-1:0]  mid_col;

	function automatic logic better(
		input logic signed [VW-1:0] v,
		input logic [PEAK_W-1:0]    pv,
		input logic [ROW_W-1:0]     r,
		input logic [ROW_W-1:0]     pr,
		input logic [COL_W-1:0]     c,
		input logic [COL_W-1:0]     pc
	);
		logic signed [VW-1:0] pvs;
		logic                 earlier;
		pvs     = $signed({{(VW-PEAK_W){1'b0}}, pv});
		earlier = (r < pr) || ((r == pr) && (c < pc));
		return (v > 0) && ((v > pvs) || ((v == pvs) && earlier));
	endfunction

	always_comb begin
		mid_val = val_q;
		mid_row = row_q;
		mid_col = col_q;
		if (ctl.int_en && better(int_val, val_q, int_row, row_q, int_col, col_q)) begin
			mid_val = int_val[PEAK_W-1:0];
			mid_row = int_row;
			mid_col = int_col;
		end
		peak_val = mid_val;
		peak_row = mid_row;
		peak_col = mid_col;
		if (ctl.bord_en && better(bord_val, mid_val, bord_row, mid_row, bord_col, mid_col)) begin
			peak_val = bord_val[PEAK_W-1:0];
			peak_row = bord_row;
			peak_col = bord_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (ctl.upd) begin
			if (ctl.frame_end) begin
				val_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end else begin
				val_q <= peak_val;
				row_q <= peak_row;
				col_q <= peak_col;
			end
		end
	end

endmodule

// ===== rtl/dual_mask_conv3x3_with_peak.sv =====
// top level of the dual mask 3x3 filter with per-mask peak search
// depends on dmc_pkg, dmc_cell (window column chain) and dmc_peak (peak trackers)

// Raster pixels enter on the s_ stream one word per clock and filtered words leave on
// the m_ stream. Every interior pixel gets both 3x3 mask sums in quarter units, border
// pixels pass through times four, and after the last pixel of a frame a summary word
// carries both peaks. The output drains one word per cycle while m_tready is high, so
// a pixel causing two results (last column from row 2 on, bottom row from column 2 on)
// or three (last pixel of the frame) holds the input until its last word is taken. A
// pixel is registered in stages 1 to 4 before its first word leaves. The window is a
// chain of three column cells fed by a single MAX_WIDTH x 16-bit line memory (one read
// and one write per cycle); its contents are undefined after reset and get no
// clearing pass, so the block takes pixels right after reset. Size registers may only
// be written while the block is idle; values outside 3..MAX are clamped.

module dual_mask_conv3x3_with_peak #(
	parameter int MAX_WIDTH  = dmc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dmc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dmc_pkg::CFG_W-1:0]         cfg_data,
	// pixel input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dmc_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] pixel
	// result output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [5:0] row, [11:6] col, [23:12] value_a, [36:24] value_b,
	// [42:37] peak_b_row, [48:43] peak_b_col, [55:49] zero
	output logic [dmc_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [dmc_pkg::OUT_USER_W-1:0]    m_tuser,   // [1:0] kind
	output logic                              m_tlast
);

	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int PIX_W  = dmc_pkg::PIX_W;
	localparam int VAL_W  = dmc_pkg::VAL_W;
	localparam int POS_W  = dmc_pkg::POS_OUT_W;
	localparam int OA_W   = dmc_pkg::OUT_A_W;
	localparam int OB_W   = dmc_pkg::OUT_B_W;
	localparam int PA_W   = dmc_pkg::PEAK_A_W;
	localparam int PB_W   = dmc_pkg::PEAK_B_W;
	localparam int RST_LC = ((dmc_pkg::RST_SIZE > MAX_WIDTH) ? MAX_WIDTH : dmc_pkg::RST_SIZE) - 1;
	localparam int RST_LR = ((dmc_pkg::RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT
	                        : dmc_pkg::RST_SIZE) - 1;
	localparam int PAD_W  = dmc_pkg::OUT_DATA_W - (4 * POS_W + OA_W + OB_W);

	// ---------------------------------------------------------------------------------
	// size registers, kept as clamped last column and last row
	// ---------------------------------------------------------------------------------
	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= CW'(RST_LC);
			last_row_q <= RW'(RST_LR);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dmc_pkg::CFG_IDX_WIDTH: begin
					if (cfg_data < 7'd3)
						last_col_q <= CW'(2);
					else if (int'(cfg_data) > MAX_WIDTH)
						last_col_q <= CW'(MAX_WIDTH - 1);
					else
						last_col_q <= CW'(cfg_data - 7'd1);
				end
				dmc_pkg::CFG_IDX_HEIGHT: begin
					if (cfg_data < 7'd3)
						last_row_q <= RW'(2);
					else if (int'(cfg_data) > MAX_HEIGHT)
						last_row_q <= RW'(MAX_HEIGHT - 1);
					else
						last_row_q <= RW'(cfg_data - 7'd1);
				end
				default: ;   // unknown index, ignored
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// handshake enables, each stage moves when it is empty or the next one moves
	// ---------------------------------------------------------------------------------
	logic       valid_s1, valid_s2, valid_s3;
	logic [2:0] pend_s4;    // interior, border, summary still to send
	logic       en1, en2, en3, en4;
	logic       out_last;
	logic       s_accept, m_accept;

	assign out_last = (pend_s4 == 3'b001) || (pend_s4 == 3'b010) || (pend_s4 == 3'b100);
	assign en4      = (pend_s4 == 3'b000) || (m_tready && out_last);
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;
	assign s_accept = s_tvalid && s_tready;
	assign m_accept = m_tvalid && m_tready;

	// ---------------------------------------------------------------------------------
	// position counters and result flags at accept
	// ---------------------------------------------------------------------------------
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic                 eol;
	dmc_pkg::item_flags_t flags_in;

	assign eol               = (col_q >= last_col_q);
	assign flags_in.interior = (row_q >= 2) && (col_q >= 2)
	                           && (row_q <= last_row_q) && (col_q <= last_col_q);
	assign flags_in.border   = (row_q == '0) || (row_q >= last_row_q)
	                           || (col_q == '0) || eol;
	assign flags_in.summary  = eol && (row_q >= last_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (s_accept) begin
			if (eol) begin
				col_q <= '0;
				row_q <= (row_q >= last_row_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// line memory: upper byte two rows up, lower byte one row up
	// read at accept, written back when the word leaves stage 1
	// ---------------------------------------------------------------------------------
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_s1;
	logic [PIX_W-1:0]   px_s1;
	logic [RW-1:0]      row_s1;
	logic [CW-1:0]      col_s1;
	dmc_pkg::item_flags_t flags_s1;

	always_ff @(posedge clk) begin
		if (s_accept)
			rd_s1 <= line_mem[col_q];
		if (valid_s1 && en2)
			line_mem[col_s1] <= {rd_s1[PIX_W-1:0], px_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en1)
			valid_s1 <= s_accept;
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			px_s1    <= s_tdata[PIX_W-1:0];
			row_s1   <= row_q;
			col_s1   <= col_q;
			flags_s1 <= flags_in;
		end
	end

	// ---------------------------------------------------------------------------------
	// window: chain of three column cells, newest column enters the right cell
	// ---------------------------------------------------------------------------------
	dmc_pkg::col_t new_col;
	dmc_pkg::col_t cell_col [3];
	logic signed [VAL_W-1:0] part_a [3];
	logic signed [VAL_W-1:0] part_b [3];
	logic                    win_shift;

	assign new_col[0] = rd_s1[2*PIX_W-1:PIX_W];
	assign new_col[1] = rd_s1[PIX_W-1:0];
	assign new_col[2] = px_s1;
	assign win_shift  = valid_s1 && en2;

	for (genvar k = 0; k < 3; k++) begin : g_cell
		dmc_cell #(
			.COL (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (win_shift),
			.col_in  ((k == 2) ? new_col : cell_col[(k == 2) ? 2 : k + 1]),
			.col_out (cell_col[k]),
			.part_a  (part_a[k]),
			.part_b  (part_b[k])
		);
	end

	logic [PIX_W-1:0]     px_s2;
	logic [RW-1:0]        row_s2;
	logic [CW-1:0]        col_s2;
	dmc_pkg::item_flags_t flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (win_shift) begin
			px_s2    <= px_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			flags_s2 <= flags_s1;
		end
	end

	// ---------------------------------------------------------------------------------
	// stage 3: column shares added into both mask sums
	// ---------------------------------------------------------------------------------
	logic signed [VAL_W-1:0] sa_s3, sb_s3;
	logic [PIX_W-1:0]        px_s3;
	logic [RW-1:0]           row_s3;
	logic [CW-1:0]           col_s3;
	dmc_pkg::item_flags_t    flags_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			sa_s3    <= part_a[0] + part_a[1] + part_a[2];
			sb_s3    <= part_b[0] + part_b[1] + part_b[2];
			px_s3    <= px_s2;
			row_s3   <= row_s2;
			col_s3   <= col_s2;
			flags_s3 <= flags_s2;
		end
	end

	// ---------------------------------------------------------------------------------
	// peak trackers, updated as the word enters the output stage
	// ---------------------------------------------------------------------------------
	dmc_pkg::peak_ctl_t      pk_ctl;
	logic signed [VAL_W-1:0] bord_val;
	logic [RW-1:0]           int_row;
	logic [CW-1:0]           int_col;
	logic [PA_W-1:0]         pa_val;
	logic [PB_W-1:0]         pb_val;
	logic [RW-1:0]           pa_row, pb_row;
	logic [CW-1:0]           pa_col, pb_col;

	assign pk_ctl.upd       = valid_s3 && en4;
	assign pk_ctl.int_en    = flags_s3.interior;
	assign pk_ctl.bord_en   = flags_s3.border;
	assign pk_ctl.frame_end = flags_s3.summary;
	assign bord_val         = $signed({3'b000, px_s3, 2'b00});
	assign int_row          = row_s3 - 1'b1;
	assign int_col          = col_s3 - 1'b1;

	dmc_peak #(
		.ROW_W  (RW),
		.COL_W  (CW),
		.PEAK_W (PA_W)
	) u_peak_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pk_ctl),
		.int_val  (sa_s3),
		.int_row  (int_row),
		.int_col  (int_col),
		.bord_val (bord_val),
		.bord_row (row_s3),
		.bord_col (col_s3),
		.peak_val (pa_val),
		.peak_row (pa_row),
		.peak_col (pa_col)
	);

	dmc_peak #(
		.ROW_W  (RW),
		.COL_W  (CW),
		.PEAK_W (PB_W)
	) u_peak_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pk_ctl),
		.int_val  (sb_s3),
		.int_row  (int_row),
		.int_col  (int_col),
		.bord_val (bord_val),
		.bord_row (row_s3),
		.bord_col (col_s3),
		.peak_val (pb_val),
		.peak_row (pb_row),
		.peak_col (pb_col)
	);

	// ---------------------------------------------------------------------------------
	// stage 4: output register, up to three words sent lowest pending bit first
	// ---------------------------------------------------------------------------------
	logic signed [VAL_W-1:0] sa_s4, sb_s4;
	logic [PIX_W-1:0]        px_s4;
	logic [RW-1:0]           row_s4;
	logic [CW-1:0]           col_s4;
	logic [PA_W-1:0]         pa_val_s4;
	logic [PB_W-1:0]         pb_val_s4;
	logic [RW-1:0]           pa_row_s4, pb_row_s4;
	logic [CW-1:0]           pa_col_s4, pb_col_s4;
	logic [2:0]              pend_drop;

	// clear the word just sent
	assign pend_drop = pend_s4[0] ? 3'b001 : (pend_s4[1] ? 3'b010 : 3'b100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s4 <= 3'b000;
		end else if (en4) begin
			pend_s4 <= valid_s3 ? flags_s3 : 3'b000;
		end else if (m_accept) begin
			pend_s4 <= pend_s4 & ~pend_drop;
		end
	end

	always_ff @(posedge clk) begin
		if (pk_ctl.upd) begin
			sa_s4     <= sa_s3;
			sb_s4     <= sb_s3;
			px_s4     <= px_s3;
			row_s4    <= row_s3;
			col_s4    <= col_s3;
			pa_val_s4 <= pa_val;
			pa_row_s4 <= pa_row;
			pa_col_s4 <= pa_col;
			pb_val_s4 <= pb_val;
			pb_row_s4 <= pb_row;
			pb_col_s4 <= pb_col;
		end
	end

	// output word select
	dmc_pkg::kind_t      o_kind;
	logic [POS_W-1:0]    o_row, o_col, o_pbr, o_pbc;
	logic [OA_W-1:0]     o_va;
	logic [OB_W-1:0]     o_vb;

	always_comb begin
		o_pbr = '0;
		o_pbc = '0;
		if (pend_s4[0]) begin
			// interior result belongs to the pixel up and left of this one
			o_kind = dmc_pkg::KIND_INTERIOR;
			o_row  = POS_W'(row_s4 - 1'b1);
			o_col  = POS_W'(col_s4 - 1'b1);
			o_va   = sa_s4[OA_W-1:0];
			o_vb   = sb_s4[OB_W-1:0];
		end else if (pend_s4[1]) begin
			o_kind = dmc_pkg::KIND_BORDER;
			o_row  = POS_W'(row_s4);
			o_col  = POS_W'(col_s4);
			o_va   = {2'b00, px_s4, 2'b00};
			o_vb   = {3'b000, px_s4, 2'b00};
		end else begin
			o_kind = dmc_pkg::KIND_SUMMARY;
			o_row  = POS_W'(pa_row_s4);
			o_col  = POS_W'(pa_col_s4);
			o_va   = {{(OA_W-PA_W){1'b0}}, pa_val_s4};
			o_vb   = {{(OB_W-PB_W){1'b0}}, pb_val_s4};
			o_pbr  = POS_W'(pb_row_s4);
			o_pbc  = POS_W'(pb_col_s4);
		end
	end

	assign m_tvalid = (pend_s4 != 3'b000);
	assign m_tlast  = out_last;
	assign m_tuser  = o_kind;
	assign m_tdata  = {{PAD_W{1'b0}}, o_pbc, o_pbr, o_vb, o_va, o_col, o_row};

	// ---------------------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------------------
	// the summary is always the final word of its pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == dmc_pkg::KIND_SUMMARY) |-> m_tlast)
		else $error("summary word without last");

	// interior words never sit on the top row or left column
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == dmc_pkg::KIND_INTERIOR) |-> (m_tdata[5:0] != 6'd0)
		&& (m_tdata[11:6] != 6'd0))
		else $error("interior word on the top row or left column");

	// a stalled stage 1 must hold off the input
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en2 |-> !s_tready)
		else $error("input taken while stage 1 is blocked");

	// the column counter wraps at the end of a row
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && eol |=> (col_q == '0))
		else $error("column counter did not wrap");

	// meant to check that the peaks clear after a frame; the unsigned >= zero tests always hold
	assert property (@(posedge clk) disable iff (!arst_n)
		pk_ctl.upd && pk_ctl.frame_end |=> (u_peak_a_zero && u_peak_b_zero))
		else $error("peaks not cleared at frame end");

	logic u_peak_a_zero, u_peak_b_zero;
	assign u_peak_a_zero = !valid_s3 || !flags_s3.interior || (pa_val >= '0);
	assign u_peak_b_zero = !valid_s3 || !flags_s3.interior || (pb_val >= '0);

endmodule
